// ----- hdl/gpdh_pkg.sv -----
// Package for the grid point dedup hash table.
// Sizes, hash constants and the key packing; no dependencies.
`timescale 1ns / 1ps
package gpdh_pkg;
	localparam int SlotCount = 4096;
	localparam int SlotBits = $clog2(SlotCount);
	localparam int EntryBits = SlotBits + 1;
	localparam int CoordBits = 21;
	localparam int KeyBits = 3 * CoordBits;
	localparam int IndexBits = 12;
	localparam int LoadLimit = (SlotCount * 7) / 10;
	localparam logic [63:0] MulA = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MulB = 64'h94d049bb133111eb;

	typedef logic [KeyBits-1:0] key_t;
	typedef logic [SlotBits-1:0] slot_t;
	typedef logic [EntryBits-1:0] entry_t;
endpackage

// ----- hdl/grid_point_dedup_hash_table.sv -----
// Top level of the grid point dedup hash table.
// Uses gpdh_pkg; holds the hash sequencer and both memories.
//
// Usage: one request per lattice point on coord_x/y/z (valid/ready). The
// block answers with one result: point_index, is_new, status.
// Hashing runs two 64x64 products, each as four 32x32 partial-product steps
// plus one fold step. Each probe of an occupied slot reads the slot memory
// and then the key memory, each through a registered read port. The empty
// slot that ends an insert needs only the slot read. The done state then
// loads the output register, once the receiver has taken the last result.
// At 70% load a few probes are typical.
// One request is in work at a time; the next is taken once the result has
// moved into the output register, even while the receiver stalls.
// Reset: all 4096 slots are cleared by a pass of one slot per cycle after
// reset; no request is taken during that pass. The point count and the
// sticky failure flag clear at once.
// After a failure at the load limit every request skips hashing and returns
// index 0, status 1.
`timescale 1ns / 1ps
module grid_point_dedup_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [20:0] coord_x,
	input  logic [20:0] coord_y,
	input  logic [20:0] coord_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] point_index,
	output logic        is_new,
	output logic        status
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_MUL, ST_FOLD, ST_SREAD, ST_SCHK, ST_KCHK, ST_DONE
	} state_t;

	state_t state_q;
	gpdh_pkg::slot_t clr_q, slot_q;
	gpdh_pkg::key_t key_q;
	logic [63:0] v_q, acc_q;
	logic [1:0] part_q;
	logic pass_q;
	gpdh_pkg::entry_t total_q, entry_q;
	logic failed_q;
	logic [gpdh_pkg::IndexBits-1:0] res_idx_q;
	logic res_new_q, res_st_q;

	gpdh_pkg::entry_t slot_mem [gpdh_pkg::SlotCount];
	gpdh_pkg::key_t key_mem [gpdh_pkg::SlotCount];
	gpdh_pkg::entry_t slot_rd;
	gpdh_pkg::key_t key_rd;
	logic slot_we, key_we;
	gpdh_pkg::slot_t slot_wa;
	gpdh_pkg::entry_t slot_wd;

	logic [31:0] opa, opb;
	logic [63:0] prod, mulc;

	always_comb begin
		mulc = pass_q ? gpdh_pkg::MulB : gpdh_pkg::MulA;
		case (part_q)
			2'd0: begin opa = v_q[31:0]; opb = mulc[31:0]; end
			2'd1: begin opa = v_q[63:32]; opb = mulc[31:0]; end
			2'd2: begin opa = v_q[31:0]; opb = mulc[63:32]; end
			default: begin opa = v_q[63:32]; opb = mulc[63:32]; end
		endcase
		prod = opa * opb;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign slot_we = (state_q == ST_CLEAR) ||
		(state_q == ST_SCHK && slot_rd == '0 && !failed_q &&
		 32'(total_q) + 1 <= gpdh_pkg::LoadLimit);
	assign slot_wa = (state_q == ST_CLEAR) ? clr_q : slot_q;
	assign slot_wd = (state_q == ST_CLEAR) ? '0 : total_q + 1'b1;
	assign key_we = (state_q == ST_SCHK) && slot_we;

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd <= slot_mem[slot_q];
		if (key_we) key_mem[total_q[gpdh_pkg::SlotBits-1:0]] <= key_q;
		key_rd <= key_mem[slot_rd[gpdh_pkg::SlotBits-1:0] - 1'b1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			total_q <= '0;
			failed_q <= 1'b0;
			out_valid <= 1'b0;
			part_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == gpdh_pkg::slot_t'(gpdh_pkg::SlotCount - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) begin
					key_q <= {coord_z, coord_y, coord_x};
					v_q <= {1'b0, coord_z, coord_y, coord_x} ^
						({1'b0, coord_z, coord_y, coord_x} >> 30);
					acc_q <= '0;
					part_q <= '0;
					pass_q <= 1'b0;
					state_q <= failed_q ? ST_DONE : ST_MUL;
					res_idx_q <= '0; res_new_q <= 1'b0; res_st_q <= 1'b1;
				end
				ST_MUL: begin
					case (part_q)
						2'd0: acc_q <= prod;
						2'd3: acc_q <= acc_q;
						default: acc_q <= acc_q + {prod[31:0], 32'd0};
					endcase
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					part_q <= '0;
					if (!pass_q) begin
						v_q <= acc_q ^ (acc_q >> 27);
						pass_q <= 1'b1;
						acc_q <= '0;
						state_q <= ST_MUL;
					end else begin
						v_q <= acc_q ^ (acc_q >> 31);
						slot_q <= gpdh_pkg::slot_t'(acc_q ^ (acc_q >> 31));
						state_q <= ST_SREAD;
					end
				end
				ST_SREAD: state_q <= ST_SCHK;
				ST_SCHK: begin
					entry_q <= slot_rd;
					if (slot_rd == '0) begin
						if (slot_we) begin
							total_q <= total_q + 1'b1;
							res_idx_q <= total_q[gpdh_pkg::IndexBits-1:0];
							res_new_q <= 1'b1; res_st_q <= 1'b0;
						end else
							failed_q <= 1'b1;
						state_q <= ST_DONE;
					end else
						state_q <= ST_KCHK;
				end
				ST_KCHK: begin
					if (key_rd == key_q) begin
						res_idx_q <= gpdh_pkg::IndexBits'(entry_q - 1'b1);
						res_new_q <= 1'b0; res_st_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						slot_q <= slot_q + 1'b1;
						state_q <= ST_SREAD;
					end
				end
				ST_DONE: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					point_index <= res_idx_q;
					is_new <= res_new_q;
					status <= res_st_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/gpdh_checker.sv -----
// Port checker for the grid point dedup hash table.
// Bound to the top level; uses no package.
`timescale 1ns / 1ps
module gpdh_checker (
	input logic clk, arst_n, in_valid, in_ready, out_valid, out_ready,
	input logic [11:0] point_index,
	input logic is_new, status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_index))
		else $error("result dropped while stalled");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> point_index == 12'd0 && !is_new)
		else $error("failed result carries data");
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |=> !out_valid || status)
		else $error("failure not sticky");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || $past(out_valid))
		else $error("result too early");
endmodule

bind grid_point_dedup_hash_table gpdh_checker u_chk (.*);

// ----- dv/testbench.sv -----
// Testbench for grid_point_dedup_hash_table: lattice point requests against an in-bench
// copy of the hash table, with random idling, a long output hold-off and a heavy fill.
// Depends on gpdh_pkg and the block's RTL only.
`timescale 1ns / 1ps
module testbench;
	localparam int MaxCoord = (1 << gpdh_pkg::CoordBits) - 1;
	localparam int WatchLimit = 20000;

	typedef struct packed {
		logic [gpdh_pkg::IndexBits-1:0] point_index;
		logic is_new;
		logic status;
	} dedup_res_t;

	typedef struct {
		int x;
		int y;
		int z;
		bit typed;
		dedup_res_t res;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [20:0] coord_x = 0;
	logic [20:0] coord_y = 0;
	logic [20:0] coord_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [11:0] point_index;
	logic is_new;
	logic status;

	grid_point_dedup_hash_table u_dut (.*);

	always #1 clk = ~clk;

	// shadow table
	int slot_map [gpdh_pkg::SlotCount];
	gpdh_pkg::key_t point_store [gpdh_pkg::SlotCount];
	int stored_points;
	bit table_failed;
	gpdh_pkg::key_t seen_keys [$];
	dedup_res_t result_fifo [$];

	int sent;
	int errors;
	int idle_cycles;
	int hold_left;
	bit hold_armed;
	int recv_pct;

	dir_row_t dir_tbl [12] = '{
		'{0, 0, 0, 1, '{12'd0, 1'b1, 1'b0}},
		'{0, 0, 0, 1, '{12'd0, 1'b0, 1'b0}},
		'{MaxCoord, MaxCoord, MaxCoord, 1, '{12'd1, 1'b1, 1'b0}},
		'{MaxCoord, MaxCoord, MaxCoord, 1, '{12'd1, 1'b0, 1'b0}},
		'{MaxCoord, 0, 0, 0, '{12'd0, 1'b0, 1'b0}},
		'{0, MaxCoord, 0, 0, '{12'd0, 1'b0, 1'b0}},
		'{0, 0, MaxCoord, 0, '{12'd0, 1'b0, 1'b0}},
		'{1, 0, 0, 0, '{12'd0, 1'b0, 1'b0}},
		'{0, 1, 0, 0, '{12'd0, 1'b0, 1'b0}},
		'{0, 0, 1, 0, '{12'd0, 1'b0, 1'b0}},
		'{MaxCoord, 0, 0, 0, '{12'd0, 1'b0, 1'b0}},
		'{0, 0, 0, 0, '{12'd0, 1'b0, 1'b0}}
	};

	function automatic logic [63:0] mix_key(logic [63:0] v);
		v = v ^ (v >> 30);
		v = v * gpdh_pkg::MulA;
		v = v ^ (v >> 27);
		v = v * gpdh_pkg::MulB;
		return v ^ (v >> 31);
	endfunction

	function automatic dedup_res_t dedup_point(logic [20:0] x, logic [20:0] y, logic [20:0] z);
		gpdh_pkg::key_t key;
		int slot;
		dedup_res_t r;
		r = '0;
		r.status = 1'b1;
		if (table_failed)
			return r;
		key = {z, y, x};
		slot = int'(mix_key({1'b0, key}) & (gpdh_pkg::SlotCount - 1));
		for (int p = 0; p < gpdh_pkg::SlotCount; p++) begin
			if (slot_map[slot] == 0) begin
				if ((stored_points + 1) * 10 > gpdh_pkg::SlotCount * 7)
					break;
				point_store[stored_points] = key;
				slot_map[slot] = stored_points + 1;
				seen_keys.push_back(key);
				r.point_index = stored_points[gpdh_pkg::IndexBits-1:0];
				r.is_new = 1'b1;
				r.status = 1'b0;
				stored_points++;
				return r;
			end else if (point_store[slot_map[slot] - 1] == key) begin
				r.point_index = gpdh_pkg::IndexBits'(slot_map[slot] - 1);
				r.status = 1'b0;
				return r;
			end
			slot = (slot + 1) % gpdh_pkg::SlotCount;
		end
		table_failed = 1;
		return r;
	endfunction

	function automatic int idle_phase();
		return (sent / 150) % 4;
	endfunction

	task automatic send_point(logic [20:0] x, logic [20:0] y, logic [20:0] z, bit typed,
			dedup_res_t typed_res);
		int pct;
		bit hit;
		dedup_res_t pred;
		pct = (idle_phase() == 1) ? 61 : (idle_phase() == 3) ? 9 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do begin
			@(negedge clk);
			hit = in_ready;
			if (hit) begin
				pred = dedup_point(x, y, z);
				result_fifo.push_back(typed ? typed_res : pred);
				sent++;
			end
			@(posedge clk);
		end while (!hit);
	endtask

	task automatic send_random(int fresh_pct);
		logic [20:0] x, y, z;
		gpdh_pkg::key_t k;
		int sel;
		sel = $urandom_range(99);
		x = 21'($urandom);
		y = 21'($urandom);
		z = 21'($urandom);
		if (sel >= fresh_pct && seen_keys.size() > 0) begin
			k = seen_keys[$urandom_range(seen_keys.size() - 1)];
			{z, y, x} = k;
		end else if (sel < 10) begin
			x = 21'($urandom_range(3));
			y = 21'($urandom_range(3));
			z = 21'($urandom_range(3));
		end else if (sel < 20) begin
			x = $urandom_range(1) ? 21'(MaxCoord) : 21'd0;
			y = $urandom_range(1) ? 21'(MaxCoord) : 21'd0;
			z = $urandom_range(1) ? 21'(MaxCoord) : 21'd0;
		end
		send_point(x, y, z, 1'b0, '0);
		if (sent == 600) begin
			in_valid <= 1'b0;
			while (result_fifo.size() != 0)
				@(posedge clk);
		end
	endtask

	initial begin
		int post;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_tbl[i])
			send_point(21'(dir_tbl[i].x), 21'(dir_tbl[i].y), 21'(dir_tbl[i].z),
				dir_tbl[i].typed, dir_tbl[i].res);
		repeat (1200)
			send_random(60);
		repeat (350)
			send_random(85);
		post = 0;
		while (post < 40) begin
			send_random(50);
			post++;
		end
		in_valid <= 1'b0;
		while (result_fifo.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_armed && sent >= 400) begin
			hold_armed <= 1'b1;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else begin
			recv_pct = (idle_phase() == 2) ? 61 : (idle_phase() == 3) ? 9 : 0;
			out_ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	always @(negedge clk) begin
		dedup_res_t exp_res;
		if (out_valid && out_ready) begin
			if (result_fifo.size() == 0) begin
				errors++;
				$display("%0t: unexpected result idx=%0d new=%0b st=%0b", $time,
					point_index, is_new, status);
			end else begin
				exp_res = result_fifo.pop_front();
				if (exp_res.point_index !== point_index) begin
					errors++;
					$display("%0t: point_index exp %0d got %0d", $time,
						exp_res.point_index, point_index);
				end
				if (exp_res.is_new !== is_new) begin
					errors++;
					$display("%0t: is_new exp %0b got %0b", $time, exp_res.is_new, is_new);
				end
				if (exp_res.status !== status) begin
					errors++;
					$display("%0t: status exp %0b got %0b", $time, exp_res.status, status);
				end
			end
		end
		if ((out_valid && out_ready) || (in_valid && in_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchLimit) begin
			$display("Verification failed");
			$finish;
		end
	end
endmodule
